### hw/rtl/nfc_pkg.sv
// Shared types, sizes and command codes for the NOR flash command model.
// No dependencies; nfc_dp, nfc_ctl and the top level import this package.
`default_nettype none
package nfc_pkg;

   localparam int unsigned FLASH_BYTES       = 1048576;
   localparam int unsigned WINDOW_BYTES      = 128;
   localparam int unsigned ERASE_BLOCK_BYTES = 65536;

   localparam int ADDR_W = 20;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 3;
   localparam int ARR_AW = $clog2(FLASH_BYTES);
   localparam int WIN_AW = $clog2(WINDOW_BYTES);
   localparam int CNT_W  = ARR_AW + 1;
   localparam int SUM_W  = CNT_W + 1;

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(4);

   // command bytes
   localparam logic [7:0] CMD_CONFIRM    = 8'hD0;
   localparam logic [7:0] CMD_PROGRAM    = 8'h10;
   localparam logic [7:0] CMD_PROGRAM_2  = 8'h40;
   localparam logic [7:0] CMD_ERASE      = 8'h20;
   localparam logic [7:0] CMD_CLR_STATUS = 8'h50;
   localparam logic [7:0] CMD_RD_STATUS  = 8'h70;
   localparam logic [7:0] CMD_RD_ID      = 8'h90;
   localparam logic [7:0] CMD_CFI        = 8'h98;
   localparam logic [7:0] CMD_RESET      = 8'hFF;
   localparam logic [7:0] CMD_RESET_2    = 8'hF0;

   localparam logic [7:0]  STATUS_READY = 8'h80;
   localparam logic [15:0] ID_MFR       = 16'h00BF;
   localparam logic [15:0] ID_DEV       = 16'h273F;

   localparam logic [1:0] MODE_ARRAY  = 2'd0;
   localparam logic [1:0] MODE_ID     = 2'd1;
   localparam logic [1:0] MODE_STATUS = 2'd2;
   localparam logic [1:0] MODE_CFI    = 2'd3;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_CNT_CLR,
      OP_CLEAR_WR,
      OP_ERASE_WR,
      OP_BYTE_ISSUE,
      OP_RD_CAP,
      OP_PRG_WR,
      OP_SAVE_ISSUE,
      OP_SAVE_WR,
      OP_REST_ISSUE,
      OP_REST_WR,
      OP_OVL_WR,
      OP_RSP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] mode;
      logic [7:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic       func;
      logic [7:0] cmd;
      logic       rd_ok;
      logic       byte_end;
      logic       prg_end;
      logic       win_end;
      logic       ers_end;
      logic       clr_end;
      logic       cnt_nz;
      logic       rsp_free;
   } dp_stat_type;

   // overlay byte of the ID and CFI windows
   function automatic logic [7:0] ovl_byte(input logic [1:0] mode,
                                           input logic [WIN_AW-1:0] k);
      logic [7:0] b;
      b = 8'h00;
      if (mode == MODE_ID) begin
         case (k)
            WIN_AW'(0): b = ID_MFR[7:0];
            WIN_AW'(1): b = ID_MFR[15:8];
            WIN_AW'(2): b = ID_DEV[7:0];
            WIN_AW'(3): b = ID_DEV[15:8];
            default:    b = 8'hFF;
         endcase
      end else begin
         case (k)
            WIN_AW'(8'h20): b = 8'h51;
            WIN_AW'(8'h22): b = 8'h52;
            WIN_AW'(8'h24): b = 8'h59;
            WIN_AW'(8'h26): b = 8'h01;
            WIN_AW'(8'h4E): b = 8'h10;
            default:        b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/nfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### hw/rtl/nfc_dp.sv
// Datapath: request latch, sweep counter, flash array and saved window RAMs,
// read assembly and response register. Depends on nfc_pkg and nfc_ram.
`default_nettype none
module nfc_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire nfc_pkg::dp_cmd_type        cmd,
   output nfc_pkg::dp_stat_type            stat,
   input  wire logic                       req_func,
   input  wire logic [nfc_pkg::ADDR_W-1:0] req_address,
   input  wire logic [nfc_pkg::SIZE_W-1:0] req_access_size,
   input  wire logic [nfc_pkg::DATA_W-1:0] req_write_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [nfc_pkg::DATA_W-1:0] rsp_read_data
);
   import nfc_pkg::*;

   logic              func_ff, func_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SUM_W-1:0]  cur_addr;
   logic [ADDR_W-1:0] blk_base;
   logic [SUM_W-1:0]  ers_addr;
   logic [1:0]        lane;

   logic              arr_we;
   logic [ARR_AW-1:0] arr_waddr, arr_raddr;
   logic [7:0]        arr_wdata, arr_rdata;
   logic              win_we;
   logic [7:0]        win_rdata;

   assign cur_addr = SUM_W'(addr_ff) + SUM_W'(cnt_ff);
   assign blk_base = addr_ff & ~ADDR_W'(ERASE_BLOCK_BYTES - 1);
   assign ers_addr = SUM_W'(blk_base) + SUM_W'(cnt_ff);
   assign lane     = cnt_ff[1:0];

   always_comb begin
      func_in      = func_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      arr_we       = 1'b0;
      arr_waddr    = cnt_ff[ARR_AW-1:0];
      arr_wdata    = 8'hFF;
      arr_raddr    = (cmd.op == OP_SAVE_ISSUE) ? cnt_ff[ARR_AW-1:0] : cur_addr[ARR_AW-1:0];
      win_we       = 1'b0;
      unique case (cmd.op)
         OP_LOAD: begin
            func_in = req_func;
            addr_in = req_address;
            size_in = (req_access_size > MAX_SIZE) ? MAX_SIZE : req_access_size;
            data_in = req_write_data;
            cnt_in  = '0;
            acc_in  = '0;
         end
         OP_CNT_CLR: cnt_in = '0;
         OP_CLEAR_WR: begin
            arr_we = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_ERASE_WR: begin
            arr_we    = 1'b1;
            arr_waddr = ers_addr[ARR_AW-1:0];
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         OP_RD_CAP: begin
            acc_in[{lane, 3'b000} +: 8] = arr_rdata;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_PRG_WR: begin
            arr_we    = 1'b1;
            arr_waddr = cur_addr[ARR_AW-1:0];
            arr_wdata = arr_rdata & data_ff[{lane, 3'b000} +: 8];
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         OP_SAVE_WR: begin
            win_we = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_REST_WR: begin
            arr_we    = 1'b1;
            arr_wdata = win_rdata;
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         OP_OVL_WR: begin
            arr_we    = 1'b1;
            arr_wdata = (cmd.mode == MODE_STATUS) ? cmd.status
                                                  : ovl_byte(cmd.mode, cnt_ff[WIN_AW-1:0]);
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         OP_RSP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = acc_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      data_ff     <= data_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   nfc_ram #(.WIDTH(8), .DEPTH(FLASH_BYTES)) u_array (
      .clock (clock),
      .we    (arr_we),
      .waddr (arr_waddr),
      .wdata (arr_wdata),
      .raddr (arr_raddr),
      .rdata (arr_rdata)
   );

   nfc_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_window (
      .clock (clock),
      .we    (win_we),
      .waddr (cnt_ff[WIN_AW-1:0]),
      .wdata (arr_rdata),
      .raddr (cnt_ff[WIN_AW-1:0]),
      .rdata (win_rdata)
   );

   always_comb begin
      stat.func     = func_ff;
      stat.cmd      = data_ff[7:0];
      stat.rd_ok    = (size_ff != '0) &&
                      (SUM_W'(addr_ff) + SUM_W'(size_ff) <= SUM_W'(FLASH_BYTES));
      stat.byte_end = cnt_ff == CNT_W'(size_ff);
      stat.prg_end  = (cnt_ff == CNT_W'(size_ff)) || (cur_addr >= SUM_W'(FLASH_BYTES));
      stat.win_end  = cnt_ff == CNT_W'(WINDOW_BYTES);
      stat.ers_end  = (cnt_ff == CNT_W'(ERASE_BLOCK_BYTES)) ||
                      (ers_addr >= SUM_W'(FLASH_BYTES));
      stat.clr_end  = cnt_ff == CNT_W'(FLASH_BYTES);
      stat.cnt_nz   = cnt_ff != '0;
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
endmodule
`default_nettype wire

### hw/rtl/nfc_ctl.sv
// Controller: command state machine, read mode, status byte and arming flags.
// Drives the datapath by op codes; depends on nfc_pkg.
`default_nettype none
module nfc_ctl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire nfc_pkg::dp_stat_type stat,
   output nfc_pkg::dp_cmd_type       cmd
);
   import nfc_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DECODE   = 4'd2;
   localparam logic [3:0] S_RD_ISS   = 4'd3;
   localparam logic [3:0] S_RD_CAP   = 4'd4;
   localparam logic [3:0] S_RSP      = 4'd5;
   localparam logic [3:0] S_PRG_ISS  = 4'd6;
   localparam logic [3:0] S_PRG_WR   = 4'd7;
   localparam logic [3:0] S_ERASE    = 4'd8;
   localparam logic [3:0] S_SAVE_ISS = 4'd9;
   localparam logic [3:0] S_SAVE_WR  = 4'd10;
   localparam logic [3:0] S_REST_ISS = 4'd11;
   localparam logic [3:0] S_REST_WR  = 4'd12;
   localparam logic [3:0] S_OVL      = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [7:0] status_ff, status_in;
   logic       saved_ff, saved_in;
   logic       prog_ff, prog_in;
   logic       erase_ff, erase_in;
   dp_op_type  op;

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      saved_in  = saved_ff;
      prog_in   = prog_ff;
      erase_in  = erase_ff;
      op        = OP_NOP;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_end) state_in = S_IDLE;
            else op = OP_CLEAR_WR;
         end
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (!stat.func) begin
               state_in = stat.rd_ok ? S_RD_ISS : S_RSP;
            end else begin
               if (status_ff == 8'h00) status_in = STATUS_READY;
               if (prog_ff) begin
                  prog_in   = 1'b0;
                  status_in = STATUS_READY;
                  mode_in   = MODE_STATUS;
                  state_in  = S_PRG_ISS;
               end else if (erase_ff) begin
                  erase_in = 1'b0;
                  if (stat.cmd == CMD_CONFIRM) begin
                     status_in = STATUS_READY;
                     mode_in   = MODE_STATUS;
                     state_in  = S_ERASE;
                  end
               end else begin
                  unique case (stat.cmd) inside
                     CMD_PROGRAM, CMD_PROGRAM_2: begin
                        prog_in  = 1'b1;
                        mode_in  = MODE_ARRAY;
                        state_in = S_REST_ISS;
                     end
                     CMD_ERASE: begin
                        erase_in = 1'b1;
                        mode_in  = MODE_ARRAY;
                        state_in = S_REST_ISS;
                     end
                     CMD_CLR_STATUS: status_in = STATUS_READY;
                     CMD_RD_STATUS: begin
                        mode_in  = MODE_STATUS;
                        state_in = S_SAVE_ISS;
                     end
                     CMD_RD_ID: begin
                        mode_in  = MODE_ID;
                        state_in = S_SAVE_ISS;
                     end
                     CMD_CFI: begin
                        mode_in  = MODE_CFI;
                        state_in = S_SAVE_ISS;
                     end
                     CMD_RESET, CMD_RESET_2: begin
                        mode_in  = MODE_ARRAY;
                        prog_in  = 1'b0;
                        erase_in = 1'b0;
                        state_in = S_REST_ISS;
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_RD_ISS: begin
            if (stat.byte_end) begin
               state_in = S_RSP;
            end else begin
               op       = OP_BYTE_ISSUE;
               state_in = S_RD_CAP;
            end
         end
         S_RD_CAP: begin
            op       = OP_RD_CAP;
            state_in = S_RD_ISS;
         end
         S_RSP: begin
            if (stat.rsp_free) begin
               op       = OP_RSP;
               state_in = S_IDLE;
            end
         end
         S_PRG_ISS: begin
            if (stat.prg_end) begin
               op       = OP_CNT_CLR;
               state_in = S_SAVE_ISS;
            end else begin
               op       = OP_BYTE_ISSUE;
               state_in = S_PRG_WR;
            end
         end
         S_PRG_WR: begin
            op       = OP_PRG_WR;
            state_in = S_PRG_ISS;
         end
         S_ERASE: begin
            if (stat.ers_end) begin
               op       = OP_CNT_CLR;
               state_in = S_SAVE_ISS;
            end else begin
               op = OP_ERASE_WR;
            end
         end
         S_SAVE_ISS: begin
            if (saved_ff) begin
               op       = OP_CNT_CLR;
               state_in = S_OVL;
            end else if (stat.win_end) begin
               saved_in = 1'b1;
               op       = OP_CNT_CLR;
               state_in = S_OVL;
            end else begin
               op       = OP_SAVE_ISSUE;
               state_in = S_SAVE_WR;
            end
         end
         S_SAVE_WR: begin
            op       = OP_SAVE_WR;
            state_in = S_SAVE_ISS;
         end
         S_REST_ISS: begin
            if (!saved_ff) begin
               state_in = S_IDLE;
            end else if (stat.win_end) begin
               saved_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               op       = OP_REST_ISSUE;
               state_in = S_REST_WR;
            end
         end
         S_REST_WR: begin
            op       = OP_REST_WR;
            state_in = S_REST_ISS;
         end
         S_OVL: begin
            if ((mode_ff == MODE_STATUS) ? stat.cnt_nz : stat.win_end) begin
               state_in = S_IDLE;
            end else begin
               op = OP_OVL_WR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         mode_ff   <= MODE_ARRAY;
         status_ff <= 8'h00;
         saved_ff  <= 1'b0;
         prog_ff   <= 1'b0;
         erase_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         status_ff <= status_in;
         saved_ff  <= saved_in;
         prog_ff   <= prog_in;
         erase_ff  <= erase_in;
      end
   end

   assign req_stall  = state_ff != S_IDLE;
   assign cmd.op     = op;
   assign cmd.mode   = mode_ff;
   assign cmd.status = status_ff;
endmodule
`default_nettype wire

### hw/rtl/nor_flash_command_model.sv
// Top level of the NOR flash command model: controller plus datapath.
// Depends on nfc_pkg, nfc_ctl, nfc_dp and nfc_ram.
`default_nettype none
// One request is worked at a time. After reset the block sweeps the whole
// array to the erased value 0xFF, one byte a cycle, and holds req_stall
// high meanwhile. The byte-wide array RAM has one read port with registered
// data, so each byte of a read is an issue and a capture. A simple command
// write is latched and then decoded. Entering status, ID or CFI mode saves
// the 128-byte low window first and then writes the overlay; leaving such a
// mode restores the window the same way. A program issues a read and then a
// write for each byte, an erase writes its 64 KiB block one byte a cycle.
// A finished read waits in the response register, and the next request is
// taken while it waits.
module nor_flash_command_model (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_func,
   input  wire logic [nfc_pkg::ADDR_W-1:0] req_address,
   input  wire logic [nfc_pkg::SIZE_W-1:0] req_access_size,
   input  wire logic [nfc_pkg::DATA_W-1:0] req_write_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [nfc_pkg::DATA_W-1:0] rsp_read_data
);
   import nfc_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequence the command state machine
   nfc_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // hold the request, the array and the response
   nfc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_func        (req_func),
      .req_address     (req_address),
      .req_access_size (req_access_size),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data)
   );

   // never overwrite a response that is still waiting
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_RSP |-> dp_stat.rsp_free)
      else $error("response issued while output held");

   // a byte capture always follows its array read
   a_rd_pair: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_RD_CAP |-> $past(dp_cmd.op) == OP_BYTE_ISSUE)
      else $error("read capture without issue");

   // a window save write always follows its array read
   a_save_pair: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_SAVE_WR |-> $past(dp_cmd.op) == OP_SAVE_ISSUE)
      else $error("window save without issue");
endmodule
`default_nettype wire

### sim/nor_flash_command_model_test.sv
// Self-checking testbench for the NOR flash command model: directed and random requests.
// Depends on nfc_pkg and nor_flash_command_model; keeps a byte-level image of the flash.
`timescale 1ns / 1ps
`default_nettype none
module nor_flash_command_model_test;
   import nfc_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   wire                 req_stall;
   logic                req_func = 1'b0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [SIZE_W-1:0]   req_access_size = SIZE_W'(1);
   logic [DATA_W-1:0]   req_write_data = '0;
   wire                 rsp_valid;
   logic                rsp_stall = 1'b0;
   wire  [DATA_W-1:0]   rsp_read_data;

   // Model image of the chip. Only the range near the window and a few blocks is
   // touched heavily, but the whole array is kept so that erase and reads agree.
   logic [7:0]          flash_image [FLASH_BYTES];
   logic [7:0]          window_copy [WINDOW_BYTES];
   logic                window_held;
   logic [7:0]          status_reg;
   logic                program_due;
   logic                erase_due;

   logic [DATA_W-1:0]   read_data_queue [$];
   int                  mismatch_count;
   bit                  quiet_rsp;          // hold rsp_stall low for the final wait

   nor_flash_command_model u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_address     (req_address),
      .req_access_size (req_access_size),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Generous limit: covers the reset sweep plus the erases.
   initial begin
      #400_000_000;
      $display("nor_flash_command_model_test: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- model
   task automatic keep_window();
      if (!window_held) begin
         for (int k = 0; k < WINDOW_BYTES; k++) window_copy[k] = flash_image[k];
         window_held = 1'b1;
      end
   endtask

   task automatic return_window();
      if (window_held) begin
         for (int k = 0; k < WINDOW_BYTES; k++) flash_image[k] = window_copy[k];
         window_held = 1'b0;
      end
   endtask

   task automatic enter_status_mode();
      keep_window();
      flash_image[0] = status_reg;
   endtask

   task automatic enter_id_mode();
      keep_window();
      for (int k = 0; k < WINDOW_BYTES; k++) flash_image[k] = 8'hFF;
      flash_image[0] = ID_MFR[7:0];
      flash_image[1] = ID_MFR[15:8];
      flash_image[2] = ID_DEV[7:0];
      flash_image[3] = ID_DEV[15:8];
   endtask

   task automatic enter_cfi_mode();
      keep_window();
      for (int k = 0; k < WINDOW_BYTES; k++) flash_image[k] = 8'h00;
      flash_image[8'h20] = 8'h51;
      flash_image[8'h22] = 8'h52;
      flash_image[8'h24] = 8'h59;
      flash_image[8'h26] = 8'h01;
      flash_image[8'h27] = 8'h00;
      flash_image[8'h4E] = 8'h10;
      flash_image[8'h4F] = 8'h00;
   endtask

   // Apply one request to the image; push the read data a read produces.
   task automatic predict_flash_access(input logic func, input logic [ADDR_W-1:0] addr,
                                       input logic [SIZE_W-1:0] size_in,
                                       input logic [DATA_W-1:0] data);
      int unsigned nbytes;
      int unsigned base;
      logic [DATA_W-1:0] value;
      logic [7:0] cmd;
      nbytes = (size_in > MAX_SIZE) ? 4 : size_in;
      cmd = data[7:0];
      if (!func) begin
         value = '0;
         if (addr + nbytes <= FLASH_BYTES)
            for (int k = 0; k < nbytes; k++) value[8*k +: 8] = flash_image[addr + k];
         read_data_queue.push_back(value);
         return;
      end
      if (status_reg == 8'h00) status_reg = STATUS_READY;
      if (program_due) begin
         for (int k = 0; k < nbytes && addr + k < FLASH_BYTES; k++)
            flash_image[addr + k] &= data[8*k +: 8];
         status_reg = STATUS_READY;
         program_due = 1'b0;
         enter_status_mode();
         return;
      end
      if (erase_due) begin
         erase_due = 1'b0;
         if (cmd == CMD_CONFIRM) begin
            base = (addr / ERASE_BLOCK_BYTES) * ERASE_BLOCK_BYTES;
            for (int k = 0; k < ERASE_BLOCK_BYTES && base + k < FLASH_BYTES; k++)
               flash_image[base + k] = 8'hFF;
            status_reg = STATUS_READY;
            enter_status_mode();
         end
         return;
      end
      case (cmd)
         CMD_PROGRAM, CMD_PROGRAM_2: begin
            return_window();
            program_due = 1'b1;
         end
         CMD_ERASE: begin
            return_window();
            erase_due = 1'b1;
         end
         CMD_CLR_STATUS: status_reg = STATUS_READY;
         CMD_RD_STATUS:  enter_status_mode();
         CMD_RD_ID:      enter_id_mode();
         CMD_CFI:        enter_cfi_mode();
         CMD_RESET, CMD_RESET_2: begin
            return_window();
            program_due = 1'b0;
            erase_due = 1'b0;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- driving
   // Mostly short gaps, now and then a long one.
   function automatic int gap_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one request, predict it, and wait until it is accepted.
   task automatic send_request(input logic func, input logic [ADDR_W-1:0] addr,
                               input logic [SIZE_W-1:0] size_in,
                               input logic [DATA_W-1:0] data);
      int idle;
      idle = gap_cycles();
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_address     <= addr;
      req_access_size <= size_in;
      req_write_data  <= data;
      predict_flash_access(func, addr, size_in, data);
      do @(posedge clock); while (req_stall);
      // leave valid high: the next send either drives a new request at this
      // edge or drops it after the gap; the last one is dropped by drain_reads
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_cmd(input logic [ADDR_W-1:0] addr, input logic [7:0] cmd);
      send_request(1'b1, addr, SIZE_W'(1), {$urandom} & 32'hFFFF_FF00 | cmd);
   endtask

   task automatic read_at(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] sz);
      send_request(1'b0, addr, sz, $urandom);
   endtask

   // Hold the sender until every expected read has come back.
   task automatic drain_reads();
      drop_valid();
      while (read_data_queue.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (read_data_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected read data %h", rsp_read_data);
            end else begin
               logic [DATA_W-1:0] want;
               want = read_data_queue.pop_front();
               if (rsp_read_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("read data mismatch: expected %h, got %h",
                              want, rsp_read_data);
               end
            end
         end
         // stall the result side in random bursts, with calm stretches
         if (quiet_rsp) rsp_stall <= 1'b0;
         else if (gap_cycles() > 0) rsp_stall <= 1'b1;
         else rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reads_after_reset();
      read_at('0, SIZE_W'(1));
      read_at(ADDR_W'(FLASH_BYTES - 4), SIZE_W'(4));
      read_at(ADDR_W'(FLASH_BYTES - 2), SIZE_W'(4));   // runs past the end
      read_at(ADDR_W'(FLASH_BYTES - 1), SIZE_W'(1));
      read_at(ADDR_W'(100), SIZE_W'(0));               // zero-size read
      read_at(ADDR_W'(200), SIZE_W'(7));               // oversized read
   endtask

   task automatic test_program_and_modes();
      write_cmd(ADDR_W'(5), CMD_PROGRAM);
      send_request(1'b1, ADDR_W'(4), SIZE_W'(4), 32'h1234_5678);
      read_at('0, SIZE_W'(4));                         // status overlay at byte 0
      read_at(ADDR_W'(4), SIZE_W'(4));
      write_cmd('0, CMD_RD_ID);
      read_at('0, SIZE_W'(4));
      read_at(ADDR_W'(WINDOW_BYTES - 4), SIZE_W'(4));
      write_cmd('0, CMD_CFI);
      read_at(ADDR_W'(8'h20), SIZE_W'(4));
      read_at(ADDR_W'(8'h4C), SIZE_W'(4));
      write_cmd('0, CMD_CLR_STATUS);
      write_cmd('0, CMD_RESET);                        // window comes back
      read_at(ADDR_W'(4), SIZE_W'(4));
      write_cmd('0, CMD_PROGRAM_2);
      send_request(1'b1, ADDR_W'(FLASH_BYTES - 2), SIZE_W'(4), 32'h0000_0F0F);
      write_cmd('0, CMD_RESET_2);
      read_at(ADDR_W'(FLASH_BYTES - 4), SIZE_W'(4));
      write_cmd('0, 8'h33);                            // unknown command
   endtask

   task automatic test_erase();
      write_cmd('0, CMD_ERASE);
      write_cmd(ADDR_W'(3), 8'h77);                    // cancelled
      read_at(ADDR_W'(4), SIZE_W'(4));
      write_cmd('0, CMD_ERASE);
      write_cmd(ADDR_W'(FLASH_BYTES - 1), CMD_CONFIRM); // last block
      write_cmd('0, CMD_ERASE);
      write_cmd(ADDR_W'(9), CMD_CONFIRM);              // first block, then status
      read_at(ADDR_W'(4), SIZE_W'(4));
      write_cmd('0, CMD_RESET);
   endtask

   function automatic logic [ADDR_W-1:0] pick_address();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return ADDR_W'($urandom_range(0, WINDOW_BYTES + 8));
      if (roll < 7) return ADDR_W'($urandom_range(FLASH_BYTES - 8, FLASH_BYTES - 1));
      return ADDR_W'($urandom);
   endfunction

   function automatic logic [7:0] pick_command();
      logic [7:0] menu [10];
      menu = '{CMD_PROGRAM, CMD_PROGRAM_2, CMD_ERASE, CMD_CLR_STATUS, CMD_RD_STATUS,
               CMD_RD_ID, CMD_CFI, CMD_RESET, CMD_RESET_2, CMD_CONFIRM};
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return menu[$urandom_range(0, 9)];
   endfunction

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         int roll;
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            read_at(pick_address(), SIZE_W'($urandom_range(0, 7)));
         end else if (roll < 75) begin
            // program sequence with random data
            write_cmd(pick_address(), CMD_PROGRAM);
            send_request(1'b1, pick_address(), SIZE_W'($urandom_range(0, 7)), $urandom);
            n++;
         end else if (roll < 77) begin
            // erase is slow; keep it rare
            write_cmd(pick_address(), CMD_ERASE);
            write_cmd(pick_address(), ($urandom_range(0, 2) != 0) ? CMD_CONFIRM : 8'($urandom));
            n++;
         end else begin
            write_cmd(pick_address(), pick_command());
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      quiet_rsp = 1'b0;
      for (int k = 0; k < FLASH_BYTES; k++) flash_image[k] = 8'hFF;
      for (int k = 0; k < WINDOW_BYTES; k++) window_copy[k] = 8'h00;
      window_held = 1'b0;
      status_reg = 8'h00;
      program_due = 1'b0;
      erase_due = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reads_after_reset();
      test_program_and_modes();
      drain_reads();                                   // sender pause
      test_erase();
      test_random_traffic(700);
      drain_reads();
      test_random_traffic(800);
      drain_reads();
      quiet_rsp = 1'b1;
      repeat (200) @(posedge clock);

      if (mismatch_count == 0 && read_data_queue.size() == 0) begin
         $display("nor_flash_command_model_test: PASS");
      end else begin
         $display("nor_flash_command_model_test: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/nfc_pkg.sv
hw/rtl/nfc_ram.sv
hw/rtl/nfc_dp.sv
hw/rtl/nfc_ctl.sv
hw/rtl/nor_flash_command_model.sv
sim/nor_flash_command_model_test.sv
